// ===== hw/rtl/stereo_linear_resampler_48k_to_44k1_core_macros.svh =====
// ----------------------------------------------------------------------------
// resampler assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef STEREO_LINEAR_RESAMPLER_48K_TO_44K1_CORE_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_48K_TO_44K1_CORE_MACROS_SVH

// same-cycle implication
`define SLR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg
// shared constants and types of the stereo linear resampler
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int IN_BLOCK_DEF  = 480;
  localparam int OUT_BLOCK_DEF = 441;
  localparam int FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W  = 16;
  localparam int PF_W      = 9;
  localparam int PKT_CNT_W = 8;
  localparam int PKT_MAX   = 256;
  localparam int NUM_CH    = 2;

  // weight table state
  typedef enum logic {
    ST_FILL,
    ST_RUN
  } tab_state_e;

endpackage

// ===== hw/rtl/slr_wtab.sv =====
// ----------------------------------------------------------------------------
// slr_wtab
// interpolation weight memory, one entry per block remainder, filled after reset
// ----------------------------------------------------------------------------
module slr_wtab import slr_pkg::*; #(
  parameter int OUT_BLOCK = OUT_BLOCK_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int ADDR_W   = $clog2(OUT_BLOCK),
  localparam int W_W      = FRAC_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [W_W-1:0]    rd_data_o,
  output logic              busy_o
);

  localparam int RQ = (1 << FRAC_BITS) / OUT_BLOCK;
  localparam int RM = (1 << FRAC_BITS) % OUT_BLOCK;

  tab_state_e state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [W_W-1:0]    f_q, f_d;
  logic [ADDR_W-1:0] rem_q, rem_d;
  logic [ADDR_W:0]   rem_sum;
  logic              carry;

  logic [W_W-1:0] mem [OUT_BLOCK];
  logic [W_W-1:0] rd_data_q;

  // running floor((r * 2^F + OUT/2) / OUT) with its remainder
  always_comb begin
    rem_sum = {1'b0, rem_q} + (ADDR_W+1)'(RM);
    carry   = (rem_sum >= (ADDR_W+1)'(OUT_BLOCK));
    state_d = state_q;
    addr_d  = addr_q;
    f_d     = f_q;
    rem_d   = rem_q;
    unique case (state_q)
      ST_FILL: begin
        addr_d = addr_q + ADDR_W'(1);
        f_d    = f_q + W_W'(RQ) + W_W'(carry);
        rem_d  = carry ? ADDR_W'(rem_sum - (ADDR_W+1)'(OUT_BLOCK)) : rem_sum[ADDR_W-1:0];
        if (addr_q == ADDR_W'(OUT_BLOCK - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      addr_q  <= '0;
      f_q     <= '0;
      rem_q   <= ADDR_W'(OUT_BLOCK / 2);
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      f_q     <= f_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL) begin
      mem[addr_q] <= f_q;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = (state_q == ST_FILL);

endmodule

// ===== hw/rtl/stereo_linear_resampler_48k_to_44k1_core.sv =====
// throughput: one frame beat per cycle while in_stall_o is low
// path: completing beat -> stage 1 -> stage 2 -> output register -> out_valid_o
// reset: control state clears at once, then a fill sweep writes all OUT_BLOCK entries
// (441 at the default sizes) of the weight memory while in_stall_o stays high
// packet_frames resets to 256; configuration writes are taken during the sweep too
// ----------------------------------------------------------------------------
// stereo_linear_resampler_48k_to_44k1_core
// stereo linear interpolation resampler, IN_BLOCK frames in, OUT_BLOCK frames out
// ----------------------------------------------------------------------------
`include "stereo_linear_resampler_48k_to_44k1_core_macros.svh"

module stereo_linear_resampler_48k_to_44k1_core import slr_pkg::*; #(
  parameter int IN_BLOCK  = IN_BLOCK_DEF,
  parameter int OUT_BLOCK = OUT_BLOCK_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [PF_W-1:0]            cfg_wdata_i,
  // frame input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] in_left_i,
  input  logic signed [SAMPLE_W-1:0] in_right_i,
  // resampled output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_left_o,
  output logic signed [SAMPLE_W-1:0] out_right_o,
  output logic                       packet_end_o
);

  localparam int POS_W  = $clog2(IN_BLOCK);
  localparam int REM_W  = $clog2(OUT_BLOCK);
  localparam int W_W    = FRAC_BITS + 1;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + W_W + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam int STEP   = IN_BLOCK - OUT_BLOCK;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [PF_W-1:0] pf_q;
  logic [PF_W-1:0] pf_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_q <= PF_W'(PKT_MAX);
    end else if (cfg_we_i) begin
      pf_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything above 256 saturates
  always_comb begin
    if (pf_q == '0) begin
      pf_lim = PF_W'(1);
    end else if (pf_q > PF_W'(PKT_MAX)) begin
      pf_lim = PF_W'(PKT_MAX);
    end else begin
      pf_lim = pf_q;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline enables, each stage moves when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic out_vld_q, s2_vld_q, s1_vld_q;
  logic out_en, s2_en, s1_en;
  logic tab_busy;
  logic accept;

  assign out_en     = !out_vld_q || !out_stall_i;
  assign s2_en      = !s2_vld_q || out_en;
  assign s1_en      = !s1_vld_q || s2_en;
  assign in_stall_o = tab_busy || !s1_en;
  assign accept     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // position tracking, decided in the accept cycle
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] prev_q [NUM_CH];
  logic                       have_prev_q;
  logic [POS_W-1:0]           prev_pos_q, prev_pos_d;
  logic [REM_W-1:0]           out_idx_q, out_idx_d;
  logic [POS_W-1:0]           base_q, base_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [PKT_CNT_W-1:0]       pkt_cnt_q, pkt_cnt_d;
  logic [REM_W:0]             rem_sum;
  logic [PF_W-1:0]            pkt_next;
  logic                       hit;
  logic                       pend;

  assign hit      = have_prev_q && (base_q == prev_pos_q);
  assign rem_sum  = {1'b0, rem_q} + (REM_W+1)'(STEP);
  assign pkt_next = {1'b0, pkt_cnt_q} + PF_W'(1);
  assign pend     = (pkt_next >= pf_lim);

  always_comb begin
    prev_pos_d = prev_pos_q;
    out_idx_d  = out_idx_q;
    base_d     = base_q;
    rem_d      = rem_q;
    pkt_cnt_d  = pkt_cnt_q;
    if (have_prev_q) begin
      // frame position wraps at the block length
      if (prev_pos_q == POS_W'(IN_BLOCK - 1)) begin
        prev_pos_d = '0;
      end else begin
        prev_pos_d = prev_pos_q + POS_W'(1);
      end
    end
    if (hit) begin
      pkt_cnt_d = pend ? '0 : pkt_next[PKT_CNT_W-1:0];
      if (out_idx_q == REM_W'(OUT_BLOCK - 1)) begin
        // block done, next output sits at position zero
        out_idx_d = '0;
        base_d    = '0;
        rem_d     = '0;
      end else begin
        out_idx_d = out_idx_q + REM_W'(1);
        if (rem_sum >= (REM_W+1)'(OUT_BLOCK)) begin
          rem_d  = REM_W'(rem_sum - (REM_W+1)'(OUT_BLOCK));
          base_d = base_q + POS_W'(2);
        end else begin
          rem_d  = rem_sum[REM_W-1:0];
          base_d = base_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_pos_q  <= '0;
      out_idx_q   <= '0;
      base_q      <= '0;
      rem_q       <= '0;
      pkt_cnt_q   <= '0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
    end else if (accept) begin
      have_prev_q <= 1'b1;
      prev_pos_q  <= prev_pos_d;
      out_idx_q   <= out_idx_d;
      base_q      <= base_d;
      rem_q       <= rem_d;
      pkt_cnt_q   <= pkt_cnt_d;
      prev_q[0]   <= in_left_i;
      prev_q[1]   <= in_right_i;
    end
  end

  // --------------------------------------------------------------------------
  // weight memory, read at the current remainder alongside stage 1 load
  // --------------------------------------------------------------------------
  logic [W_W-1:0] weight;

  slr_wtab #(
    .OUT_BLOCK (OUT_BLOCK),
    .FRAC_BITS (FRAC_BITS)
  ) u_wtab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_en),
    .rd_addr_i (rem_q),
    .rd_data_o (weight),
    .busy_o    (tab_busy)
  );

  // --------------------------------------------------------------------------
  // stage 1: frame pair captured, only beats that produce a result are valid
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] s1_prev_q [NUM_CH];
  logic signed [SAMPLE_W-1:0] s1_cur_q  [NUM_CH];
  logic                       s1_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_en) begin
      s1_vld_q <= accept && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_prev_q[0] <= prev_q[0];
      s1_prev_q[1] <= prev_q[1];
      s1_cur_q[0]  <= in_left_i;
      s1_cur_q[1]  <= in_right_i;
      s1_pend_q    <= pend;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: (cur - prev) * f, one multiplier per channel
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]   diff  [NUM_CH];
  logic signed [PROD_W-1:0]   prod  [NUM_CH];
  logic signed [W_W:0]        wsig;
  logic signed [PROD_W-1:0]   s2_prod_q [NUM_CH];
  logic signed [SAMPLE_W-1:0] s2_prev_q [NUM_CH];
  logic                       s2_pend_q;

  assign wsig = signed'({1'b0, weight});

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      diff[c] = DIFF_W'(s1_cur_q[c]) - DIFF_W'(s1_prev_q[c]);
      prod[c] = PROD_W'(diff[c]) * PROD_W'(wsig);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_prod_q[0] <= prod[0];
      s2_prod_q[1] <= prod[1];
      s2_prev_q[0] <= s1_prev_q[0];
      s2_prev_q[1] <= s1_prev_q[1];
      s2_pend_q    <= s1_pend_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: prev * 2^F + product, scaled down with truncation toward zero
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]    acc  [NUM_CH];
  logic signed [ACC_W-1:0]    accb [NUM_CH];
  logic signed [ACC_W-1:0]    quo  [NUM_CH];
  logic signed [SAMPLE_W-1:0] mix  [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc[c]  = (ACC_W'(s2_prev_q[c]) <<< FRAC_BITS) + ACC_W'(s2_prod_q[c]);
      // negative sums get 2^F - 1 added so the shift rounds toward zero
      accb[c] = acc[c] + (acc[c][ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0));
      quo[c]  = accb[c] >>> FRAC_BITS;
      mix[c]  = quo[c][SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_left_o   <= mix[0];
      out_right_o  <= mix[1];
      packet_end_o <= s2_pend_q;
    end
  end

  assign out_valid_o = out_vld_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `SLR_ASSERT_IMPL(a_no_accept_in_fill, tab_busy, in_stall_o, "frame taken during weight fill")
  `SLR_ASSERT_IMPL(a_result_needs_prev, s1_vld_q, have_prev_q, "result without previous frame")
  `SLR_ASSERT_IMPL(a_pos_in_block, 1'b1, prev_pos_q <= POS_W'(IN_BLOCK - 1), "position past block")
  `SLR_ASSERT_NEXT(a_out_held, out_vld_q && out_stall_i, out_vld_q, "stalled result dropped")

endmodule
